/* src/oamt_pkg.sv */
// Shared types and sizing constants for the object address map table.
package oamt_pkg;

	localparam int ENTRIES   = 16;
	localparam int KEY_BYTES = 8;
	localparam int KEY_W     = KEY_BYTES * 8;
	localparam int ADDR_W    = 32;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int SLOT_W    = KEY_W + ADDR_W;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_SCAN
	} fsm_t;

endpackage

/* src/oamt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module oamt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/object_address_map_table.sv */
// Object address map table: exact-match map from object keys to IPv4 node addresses.
//
// Usage: one request transfer (req_valid/req_stall) carries an opcode, a key and an
// address; one response transfer (rsp_valid/rsp_stall) returns status, found_address
// and is_local. The user must write local_address through cfg_we/cfg_wdata only while
// the block idles; the block itself does not enforce this. Keys and addresses live in
// a single RAM with a registered read; valid bits are flip-flops. Insert, lookup and
// delete walk the slots in order, one slot per cycle on the single read port, and stop
// at the first match, so the walk sets their response time: a match in slot 0 answers
// soonest, a miss or a new key walks every slot. Clear answers without a walk. One
// request is in flight at a time; req_stall is high while a request is at work. The
// response sits in an output register, so a request may be accepted while a previous
// response still waits; if the receiver keeps rsp_stall high, the walk holds at its
// final step until the output register frees up.
// Reset clears all valid bits, local_address and the response valid at once.
module object_address_map_table
	import oamt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  opcode,
	input  logic [63:0] object_key,
	input  logic [31:0] node_address,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [31:0] found_address,
	output logic        is_local
);

	fsm_t state_q, state_d;

	logic [ADDR_W-1:0] local_address_q;
	logic [ENTRIES-1:0] valid_q;

	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [ADDR_W-1:0] addr_q;

	logic [CNT_W-1:0] rd_cnt_q;
	logic             chk_vld_s1;
	logic [IDX_W-1:0] chk_idx_s1;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	logic              rsp_valid_q;
	status_t           status_q;
	logic [ADDR_W-1:0] found_q;
	logic              local_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [SLOT_W-1:0] ram_wdata;
	logic              ram_re;
	logic [SLOT_W-1:0] ram_rdata;

	logic              req_xfer;
	logic              out_free;
	logic              rd_more;
	logic              slot_valid;
	logic              cmp_hit;
	logic              cmp_last;
	logic              finish;
	logic              advance;
	logic              cur_free;
	logic [IDX_W-1:0]  cur_free_idx;
	logic [KEY_W-1:0]  rd_key;
	logic [ADDR_W-1:0] rd_addr;

	status_t           res_status;
	logic [ADDR_W-1:0] res_found;
	logic              res_local;
	logic              set_valid;
	logic              clr_valid;
	logic              clr_all;

	assign rd_key  = ram_rdata[SLOT_W-1:ADDR_W];
	assign rd_addr = ram_rdata[ADDR_W-1:0];

	assign req_stall = (state_q != FSM_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign rd_more      = (rd_cnt_q < CNT_W'(ENTRIES));
	assign slot_valid   = valid_q[chk_idx_s1];
	assign cmp_hit      = chk_vld_s1 && slot_valid && (rd_key == key_q);
	assign cmp_last     = chk_vld_s1 && (chk_idx_s1 == IDX_W'(ENTRIES - 1));
	assign cur_free     = free_found_q || (chk_vld_s1 && !slot_valid);
	assign cur_free_idx = free_found_q ? free_idx_q : chk_idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM control and the result of the finishing step.
	always_comb begin
		state_d    = state_q;
		finish     = 1'b0;
		advance    = 1'b0;
		ram_re     = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = chk_idx_s1;
		ram_wdata  = {key_q, addr_q};
		res_status = STATUS_OK;
		res_found  = '0;
		res_local  = 1'b0;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		clr_all    = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				if (req_xfer) begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				finish  = (op_q == OP_CLEAR) || cmp_hit || cmp_last;
				advance = !finish || out_free;
				ram_re  = advance && !finish && rd_more;
				if (finish && out_free) begin
					state_d = FSM_IDLE;
					case (op_q)
						OP_INSERT: begin
							if (cmp_hit) begin
								ram_we = 1'b1;
							end else if (cur_free) begin
								ram_we    = 1'b1;
								ram_waddr = cur_free_idx;
								set_valid = 1'b1;
							end else begin
								res_status = STATUS_FULL;
							end
						end
						OP_LOOKUP: begin
							if (cmp_hit) begin
								res_found = rd_addr;
								res_local = (rd_addr == local_address_q);
							end else begin
								res_status = STATUS_MISS;
							end
						end
						OP_DELETE: begin
							if (cmp_hit) begin
								clr_valid = 1'b1;
							end else begin
								res_status = STATUS_MISS;
							end
						end
						default: begin
							clr_all = 1'b1;
						end
					endcase
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Control state: configuration, valid bits, walk position and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= '0;
			valid_q         <= '0;
			rd_cnt_q        <= '0;
			chk_vld_s1      <= 1'b0;
			free_found_q    <= 1'b0;
			rsp_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				local_address_q <= cfg_wdata;
			end
			if (clr_all) begin
				valid_q <= '0;
			end else if (set_valid) begin
				valid_q[cur_free_idx] <= 1'b1;
			end else if (clr_valid) begin
				valid_q[chk_idx_s1] <= 1'b0;
			end
			if (req_xfer) begin
				rd_cnt_q     <= '0;
				chk_vld_s1   <= 1'b0;
				free_found_q <= 1'b0;
			end else if (state_q == FSM_SCAN && advance && !finish) begin
				rd_cnt_q     <= rd_more ? rd_cnt_q + CNT_W'(1) : rd_cnt_q;
				chk_vld_s1   <= ram_re;
				free_found_q <= cur_free;
			end
			if (finish && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q   <= op_t'(opcode);
			key_q  <= object_key[KEY_W-1:0];
			addr_q <= node_address;
		end
		if (state_q == FSM_SCAN && advance && !finish) begin
			chk_idx_s1 <= rd_cnt_q[IDX_W-1:0];
			free_idx_q <= cur_free_idx;
		end
		if (finish && out_free) begin
			status_q <= res_status;
			found_q  <= res_found;
			local_q  <= res_local;
		end
	end

	oamt_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(ENTRIES)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_cnt_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign found_address = found_q;
	assign is_local      = local_q;

endmodule

/* verif/oamt_checker.sv */
// Checker for the object address map table: tracks the table and compares every response.
`timescale 1ns / 1ps

module oamt_checker
	import oamt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  opcode,
	input  logic [63:0] object_key,
	input  logic [31:0] node_address,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [1:0]  status,
	input  logic [31:0] found_address,
	input  logic        is_local,
	output int          pending_replies,
	output int          fault_count
);

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] address;
		logic              local_hit;
	} reply_t;

	localparam logic [63:0] KEY_MASK = (KEY_W >= 64) ? {64{1'b1}} : ((64'd1 << KEY_W) - 64'd1);

	logic              slot_used [ENTRIES];
	logic [63:0]       slot_keys [ENTRIES];
	logic [ADDR_W-1:0] slot_addrs [ENTRIES];
	logic [31:0]       local_ip;
	reply_t            replies_due[$];
	reply_t            due;

	// Applies one table operation to the shadow table and returns the response it should give.
	function automatic reply_t predict_table_op(op_t op, logic [63:0] raw_key, logic [31:0] addr);
		reply_t      r;
		logic [63:0] key;
		int          hit;
		int          spare;
		key = raw_key & KEY_MASK;
		r = '{status: STATUS_OK, address: '0, local_hit: 1'b0};
		hit = -1;
		spare = -1;
		// Walking downward leaves the lowest-numbered match and free slot in hand.
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (slot_used[i] && slot_keys[i] == key)
				hit = i;
			if (!slot_used[i])
				spare = i;
		end
		case (op)
			OP_INSERT: begin
				if (hit >= 0) begin
					slot_addrs[hit] = addr;
				end else if (spare >= 0) begin
					slot_used[spare] = 1'b1;
					slot_keys[spare] = key;
					slot_addrs[spare] = addr;
				end else begin
					r.status = STATUS_FULL;
				end
			end
			OP_LOOKUP: begin
				if (hit >= 0) begin
					r.address = slot_addrs[hit];
					r.local_hit = (slot_addrs[hit] == local_ip);
				end else begin
					r.status = STATUS_MISS;
				end
			end
			OP_DELETE: begin
				if (hit >= 0)
					slot_used[hit] = 1'b0;
				else
					r.status = STATUS_MISS;
			end
			default: begin
				for (int i = 0; i < ENTRIES; i++)
					slot_used[i] = 1'b0;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				slot_used[i] = 1'b0;
			local_ip = '0;
			replies_due.delete();
			pending_replies = 0;
			fault_count = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (replies_due.size() == 0) begin
					$error("status: expected no response, actual %0d", status);
					fault_count++;
				end else begin
					due = replies_due.pop_front();
					if (status !== due.status) begin
						$error("status: expected %0d, actual %0d", due.status, status);
						fault_count++;
					end
					if (found_address !== due.address) begin
						$error("found_address: expected %h, actual %h", due.address, found_address);
						fault_count++;
					end
					if (is_local !== due.local_hit) begin
						$error("is_local: expected %0d, actual %0d", due.local_hit, is_local);
						fault_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				replies_due.push_back(predict_table_op(op_t'(opcode), object_key, node_address));
			if (cfg_we)
				local_ip = cfg_wdata;
			pending_replies = replies_due.size();
		end
	end

endmodule

/* verif/tb_object_address_map_table.sv */
// Testbench top for the object address map table: stimulus, response-side stalls and verdict.
`timescale 1ns / 1ps

module tb_object_address_map_table
	import oamt_pkg::*;
();

	localparam int POOL_SIZE = 24;
	localparam int DRAIN_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  opcode = OP_LOOKUP;
	logic [63:0] object_key = '0;
	logic [31:0] node_address = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] found_address;
	logic        is_local;

	int          pending_replies;
	int          fault_count;

	bit          rsp_quiet = 1'b1;
	bit          hold_ask = 1'b0;
	logic [31:0] local_cur = '0;
	logic [63:0] key_pool [POOL_SIZE];

	object_address_map_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.opcode        (opcode),
		.object_key    (object_key),
		.node_address  (node_address),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.found_address (found_address),
		.is_local      (is_local)
	);

	oamt_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.opcode          (opcode),
		.object_key      (object_key),
		.node_address    (node_address),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.status          (status),
		.found_address   (found_address),
		.is_local        (is_local),
		.pending_replies (pending_replies),
		.fault_count     (fault_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Response side: random stall runs, a quiet mode, and a long hold-off on request.
	initial begin
		int stall_left;
		int open_left;
		int hold_left;
		stall_left = 0;
		open_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_ask) begin
				hold_ask = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (rsp_quiet) begin
				rsp_stall <= 1'b0;
			end else if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else if (open_left > 0) begin
				rsp_stall <= 1'b0;
				open_left--;
			end else begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				                                         : $urandom_range(0, 3);
				open_left = $urandom_range(1, 8);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Offers one request and returns once the transfer has been taken.
	task automatic offer(input op_t op, input logic [63:0] key, input logic [31:0] addr);
		@(negedge clk);
		req_valid <= 1'b1;
		opcode <= op;
		object_key <= key;
		node_address <= addr;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic idle(input int n);
		repeat (n) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
	endtask

	task automatic sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r >= 90)
			idle($urandom_range(10, 50));
		else if (r >= 55)
			idle($urandom_range(1, 3));
	endtask

	task automatic drain();
		int n;
		n = 0;
		idle(1);
		while (pending_replies != 0 && n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
	endtask

	task automatic set_local(input logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		local_cur = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int count, input bit gaps_on, input bit mid_drain);
		int          r;
		op_t         op;
		logic [63:0] key;
		logic [31:0] addr;
		for (int k = 0; k < count; k++) begin
			if (mid_drain && k == count / 2)
				drain();
			case ($urandom_range(0, 3))
				0: addr = local_cur;
				1: addr = '0;
				2: addr = '1;
				default: addr = $urandom;
			endcase
			r = $urandom_range(0, 99);
			if (r < 10) begin
				// Noise: keys outside the pool, which mostly miss.
				op = op_t'($urandom_range(0, 2));
				key = {$urandom, $urandom};
			end else begin
				key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
				r = $urandom_range(0, 99);
				if (r < 45)
					op = OP_INSERT;
				else if (r < 78)
					op = OP_LOOKUP;
				else if (r < 99)
					op = OP_DELETE;
				else
					op = OP_CLEAR;
			end
			offer(op, key, addr);
			if (gaps_on)
				sender_gap();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_local('0);

		// Directed part: empty table, key extremes, update, full table, delete, clear.
		offer(OP_LOOKUP, 64'h0, 32'h0);
		offer(OP_DELETE, 64'h0, 32'h0);
		offer(OP_INSERT, 64'h0, 32'h0);
		offer(OP_LOOKUP, 64'h0, 32'hFFFF_FFFF);
		offer(OP_INSERT, '1, 32'hFFFF_FFFF);
		offer(OP_LOOKUP, '1, 32'h0);
		offer(OP_INSERT, 64'h0, 32'h0A00_0001);
		for (int i = 2; i < ENTRIES; i++)
			offer(OP_INSERT, 64'h5A5A_0000_0000_0100 + 64'(i), 32'hC0A8_0000 + 32'(i));
		offer(OP_INSERT, 64'hDEAD_BEEF_0000_0001, 32'h1234_5678);
		offer(OP_INSERT, '1, 32'h7F00_0001);
		offer(OP_DELETE, 64'h0, 32'h0);
		offer(OP_LOOKUP, 64'h0, 32'h0);
		offer(OP_CLEAR, 64'h0, 32'h0);
		offer(OP_LOOKUP, '1, 32'h0);
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			for (int i = 0; i < POOL_SIZE; i++)
				key_pool[i] = {$urandom, $urandom};
			case (phase)
				0: begin
					set_local(32'hFFFF_FFFF);
					rsp_quiet = 1'b1;
					run_phase(160, 1'b0, 1'b0);
				end
				1: begin
					set_local($urandom);
					rsp_quiet = 1'b0;
					run_phase(160, 1'b1, 1'b0);
				end
				2: begin
					set_local('0);
					rsp_quiet = 1'b0;
					@(posedge clk);
					hold_ask = 1'b1;
					// The sender keeps offering through the hold-off so the block backs up.
					run_phase(40, 1'b0, 1'b0);
					run_phase(120, 1'b1, 1'b0);
				end
				3: begin
					set_local($urandom);
					key_pool[0] = '0;
					key_pool[1] = '1;
					rsp_quiet = 1'b0;
					run_phase(160, 1'b1, 1'b1);
				end
				default: begin
					set_local(32'h0A00_0001);
					rsp_quiet = 1'b1;
					run_phase(160, 1'b1, 1'b0);
				end
			endcase
			drain();
		end

		repeat (ENTRIES + 4) @(negedge clk);
		if (fault_count == 0 && pending_replies == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
src/oamt_pkg.sv
src/oamt_ram.sv
src/object_address_map_table.sv
verif/oamt_checker.sv
verif/tb_object_address_map_table.sv
